// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define TGCW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define TGCW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tgcw_pkg.sv =====
// Shared types and constants of the tile grid coordinate walk unit.
package tgcw_pkg;

    localparam int TILE_COUNT_DEF = 64;
    localparam int TILE_W         = 6;
    localparam int ADDR_W         = 8;
    localparam int COORD_W        = 7;
    localparam int SIZE_W         = 7;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [ADDR_W-1:0] north;
        logic [ADDR_W-1:0] east;
        logic [ADDR_W-1:0] south;
        logic [ADDR_W-1:0] west;
    } nb_entry_t;

    typedef struct packed {
        logic [TILE_W-1:0] id;
        coord_t            x;
        coord_t            y;
    } stack_entry_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } raw_entry_t;

    typedef enum logic [1:0] {
        DIR_N,
        DIR_E,
        DIR_S,
        DIR_W
    } dir_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POP,
        ST_FETCH,
        ST_PUSH_N,
        ST_PUSH_E,
        ST_PUSH_S,
        ST_PUSH_W,
        ST_PRIME,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic walk_init;
        logic scan_adv;
        logic start_push;
        logic pop;
        logic fetch;
        logic push;
        dir_t dir;
        logic emit_init;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic scan_hit;
        logic scan_end;
        logic stack_empty;
        logic emit_end;
    } status_t;

endpackage

// ===== hdl/tile_grid_coordinate_walk_unit.sv =====
// Top level of the tile grid coordinate walk unit: places a table of tiles on a grid.
// A word with action low loads one tile table entry and busy stays low, so loads may
// follow one another in every cycle. A word with action high runs the depth-first walk:
// the controller scans for the lowest alive tile above 0 one address per cycle, then for
// every placed tile runs a stack pop, a coordinate record with neighbour fetch, and one
// push slot for each of north, east, south and west, as the stack memory has one write
// port; a last pop step finds the stack empty and a prime step primes the coordinate
// read. It then emits TILE_COUNT results, one per cycle, in ascending tile order. When no
// tile is alive the walk and its empty-stack check are skipped. Each result is on the
// ports for exactly one cycle with strobe high and cannot be held off: the receiver must
// take every word as it comes. Last marks the word for tile TILE_COUNT-1; busy has
// already fallen in that cycle, so a new word may be accepted alongside it.
`include "assert_macros.svh"

module tile_grid_coordinate_walk_unit
#(
    parameter int TILE_COUNT = tgcw_pkg::TILE_COUNT_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              action,
    input  logic [tgcw_pkg::TILE_W-1:0]       tile_index,
    input  logic                              alive,
    input  logic [tgcw_pkg::ADDR_W-1:0]       north_addr,
    input  logic [tgcw_pkg::ADDR_W-1:0]       east_addr,
    input  logic [tgcw_pkg::ADDR_W-1:0]       south_addr,
    input  logic [tgcw_pkg::ADDR_W-1:0]       west_addr,
    output logic                              strobe,
    output logic [tgcw_pkg::TILE_W-1:0]       out_tile,
    output logic                              placed,
    output logic [tgcw_pkg::TILE_W-1:0]       grid_x,
    output logic [tgcw_pkg::TILE_W-1:0]       grid_y,
    output logic [tgcw_pkg::SIZE_W-1:0]       map_width,
    output logic [tgcw_pkg::SIZE_W-1:0]       map_height,
    output logic                              last
);

    // Commands down to the datapath, status back to the controller
    tgcw_pkg::cmd_t    cmd;
    tgcw_pkg::status_t status;

    tgcw_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Tables, stack, coordinate store and the result register
    tgcw_dp
    #(
        .TILE_COUNT (TILE_COUNT)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .tile_index (tile_index),
        .alive      (alive),
        .north_addr (north_addr),
        .east_addr  (east_addr),
        .south_addr (south_addr),
        .west_addr  (west_addr),
        .strobe     (strobe),
        .out_tile   (out_tile),
        .placed     (placed),
        .grid_x     (grid_x),
        .grid_y     (grid_y),
        .map_width  (map_width),
        .map_height (map_height),
        .last       (last)
    );

    // A result word only follows a cycle of the emit pass
    `TGCW_ASSERT(a_strobe_after_busy, strobe |-> $past(busy), "result word without a walk")
    // The final word closes the walk; earlier words leave it running
    `TGCW_ASSERT_IMPL(a_last_ends_walk, strobe && last, !busy, "walk still busy after last word")
    `TGCW_ASSERT_IMPL(a_mid_keeps_busy, strobe && !last, busy, "walk ended before last word")
    // An unplaced tile reports the origin
    `TGCW_ASSERT_IMPL(a_unplaced_zero, strobe && !placed, (grid_x == '0) && (grid_y == '0),
        "unplaced tile with nonzero coordinates")

endmodule

// ===== hdl/tgcw_ctrl.sv =====
// Controller state machine of the tile grid coordinate walk unit.
module tgcw_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             action,
    input  tgcw_pkg::status_t status,
    output tgcw_pkg::cmd_t   cmd,
    output logic             busy
);

    tgcw_pkg::state_t state_reg;
    tgcw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tgcw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tgcw_pkg::ST_IDLE:
            begin
                if (start && action)
                begin
                    state_next = tgcw_pkg::ST_SCAN;
                end
            end
            tgcw_pkg::ST_SCAN:
            begin
                if (status.scan_hit)
                begin
                    state_next = tgcw_pkg::ST_POP;
                end
                else if (status.scan_end)
                begin
                    state_next = tgcw_pkg::ST_PRIME;
                end
            end
            tgcw_pkg::ST_POP:
            begin
                if (status.stack_empty)
                begin
                    state_next = tgcw_pkg::ST_PRIME;
                end
                else
                begin
                    state_next = tgcw_pkg::ST_FETCH;
                end
            end
            tgcw_pkg::ST_FETCH:  state_next = tgcw_pkg::ST_PUSH_N;
            tgcw_pkg::ST_PUSH_N: state_next = tgcw_pkg::ST_PUSH_E;
            tgcw_pkg::ST_PUSH_E: state_next = tgcw_pkg::ST_PUSH_S;
            tgcw_pkg::ST_PUSH_S: state_next = tgcw_pkg::ST_PUSH_W;
            tgcw_pkg::ST_PUSH_W: state_next = tgcw_pkg::ST_POP;
            tgcw_pkg::ST_PRIME:  state_next = tgcw_pkg::ST_EMIT;
            tgcw_pkg::ST_EMIT:
            begin
                if (status.emit_end)
                begin
                    state_next = tgcw_pkg::ST_IDLE;
                end
            end
            default: state_next = tgcw_pkg::ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            tgcw_pkg::ST_IDLE:
            begin
                busy          = 1'b0;
                cmd.load      = start && !action;
                cmd.walk_init = start && action;
            end
            tgcw_pkg::ST_SCAN:
            begin
                cmd.start_push = status.scan_hit;
                cmd.scan_adv   = !status.scan_hit && !status.scan_end;
            end
            tgcw_pkg::ST_POP:
            begin
                cmd.pop = !status.stack_empty;
            end
            tgcw_pkg::ST_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            tgcw_pkg::ST_PUSH_N:
            begin
                cmd.push = 1'b1;
                cmd.dir  = tgcw_pkg::DIR_N;
            end
            tgcw_pkg::ST_PUSH_E:
            begin
                cmd.push = 1'b1;
                cmd.dir  = tgcw_pkg::DIR_E;
            end
            tgcw_pkg::ST_PUSH_S:
            begin
                cmd.push = 1'b1;
                cmd.dir  = tgcw_pkg::DIR_S;
            end
            tgcw_pkg::ST_PUSH_W:
            begin
                cmd.push = 1'b1;
                cmd.dir  = tgcw_pkg::DIR_W;
            end
            tgcw_pkg::ST_PRIME:
            begin
                cmd.emit_init = 1'b1;
            end
            tgcw_pkg::ST_EMIT:
            begin
                cmd.emit = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/tgcw_dp.sv =====
// Datapath of the tile grid coordinate walk unit: tables, stack and result registers.
module tgcw_dp
#(
    parameter int TILE_COUNT = tgcw_pkg::TILE_COUNT_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  tgcw_pkg::cmd_t                    cmd,
    output tgcw_pkg::status_t                 status,
    input  logic [tgcw_pkg::TILE_W-1:0]       tile_index,
    input  logic                              alive,
    input  logic [tgcw_pkg::ADDR_W-1:0]       north_addr,
    input  logic [tgcw_pkg::ADDR_W-1:0]       east_addr,
    input  logic [tgcw_pkg::ADDR_W-1:0]       south_addr,
    input  logic [tgcw_pkg::ADDR_W-1:0]       west_addr,
    output logic                              strobe,
    output logic [tgcw_pkg::TILE_W-1:0]       out_tile,
    output logic                              placed,
    output logic [tgcw_pkg::TILE_W-1:0]       grid_x,
    output logic [tgcw_pkg::TILE_W-1:0]       grid_y,
    output logic [tgcw_pkg::SIZE_W-1:0]       map_width,
    output logic [tgcw_pkg::SIZE_W-1:0]       map_height,
    output logic                              last
);

    localparam int IDX_W = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
    localparam int CNT_W = $clog2(TILE_COUNT + 1);

    // Storage
    tgcw_pkg::nb_entry_t    nb_mem    [TILE_COUNT];
    tgcw_pkg::stack_entry_t stack_mem [TILE_COUNT];
    tgcw_pkg::raw_entry_t   raw_mem   [TILE_COUNT];

    tgcw_pkg::nb_entry_t    nb_rd_reg;
    tgcw_pkg::stack_entry_t stack_rd_reg;
    tgcw_pkg::raw_entry_t   raw_rd_reg;

    logic [TILE_COUNT-1:0] alive_reg;
    logic [TILE_COUNT-1:0] visited_reg;
    logic [TILE_COUNT-1:0] placed_reg;
    logic [CNT_W-1:0]      top_reg;
    logic [IDX_W-1:0]      scan_reg;
    logic [IDX_W-1:0]      cnt_reg;
    logic                  any_reg;
    tgcw_pkg::coord_t      min_x_reg;
    tgcw_pkg::coord_t      min_y_reg;
    tgcw_pkg::coord_t      max_x_reg;
    tgcw_pkg::coord_t      max_y_reg;

    logic                         strobe_reg;
    logic [tgcw_pkg::TILE_W-1:0]  out_tile_reg;
    logic                         placed_out_reg;
    logic [tgcw_pkg::TILE_W-1:0]  grid_x_reg;
    logic [tgcw_pkg::TILE_W-1:0]  grid_y_reg;
    logic [tgcw_pkg::SIZE_W-1:0]  width_reg;
    logic [tgcw_pkg::SIZE_W-1:0]  height_reg;
    logic                         last_reg;

    logic                        load_ok;
    logic [IDX_W-1:0]            load_idx;
    logic [CNT_W-1:0]            top_dec;
    logic [IDX_W-1:0]            fetch_idx;
    logic [tgcw_pkg::ADDR_W-1:0] push_addr;
    logic [IDX_W-1:0]            push_idx;
    tgcw_pkg::coord_t            push_x;
    tgcw_pkg::coord_t            push_y;
    logic                        push_ok;
    logic [IDX_W-1:0]            cnt_inc;
    logic                        cur_placed;
    tgcw_pkg::coord_t            shift_x;
    tgcw_pkg::coord_t            shift_y;
    logic [tgcw_pkg::SIZE_W-1:0] span_x;
    logic [tgcw_pkg::SIZE_W-1:0] span_y;

    assign load_ok   = {1'b0, tile_index} < (tgcw_pkg::TILE_W + 1)'(TILE_COUNT);
    assign load_idx  = tile_index[IDX_W-1:0];
    assign top_dec   = top_reg - CNT_W'(1);
    assign fetch_idx = stack_rd_reg.id[IDX_W-1:0];
    assign cnt_inc   = cnt_reg + IDX_W'(1);

    // Neighbour selection for the current push step
    always_comb
    begin
        push_x = stack_rd_reg.x;
        push_y = stack_rd_reg.y;
        case (cmd.dir)
            tgcw_pkg::DIR_N:
            begin
                push_addr = nb_rd_reg.north;
                push_y    = stack_rd_reg.y - tgcw_pkg::COORD_W'(1);
            end
            tgcw_pkg::DIR_E:
            begin
                push_addr = nb_rd_reg.east;
                push_x    = stack_rd_reg.x + tgcw_pkg::COORD_W'(1);
            end
            tgcw_pkg::DIR_S:
            begin
                push_addr = nb_rd_reg.south;
                push_y    = stack_rd_reg.y + tgcw_pkg::COORD_W'(1);
            end
            tgcw_pkg::DIR_W:
            begin
                push_addr = nb_rd_reg.west;
                push_x    = stack_rd_reg.x - tgcw_pkg::COORD_W'(1);
            end
            default:
            begin
                push_addr = '0;
            end
        endcase
    end

    assign push_idx = push_addr[IDX_W-1:0];
    assign push_ok  = cmd.push
                      && (push_addr != '0)
                      && (push_addr < tgcw_pkg::ADDR_W'(TILE_COUNT))
                      && alive_reg[push_idx]
                      && !visited_reg[push_idx]
                      && (top_reg < CNT_W'(TILE_COUNT));

    assign status.scan_hit    = alive_reg[scan_reg];
    assign status.scan_end    = (scan_reg == IDX_W'(TILE_COUNT - 1));
    assign status.stack_empty = (top_reg == '0);
    assign status.emit_end    = (cnt_reg == IDX_W'(TILE_COUNT - 1));

    // Memory writes and registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.load && load_ok)
        begin
            nb_mem[load_idx] <= '{north: north_addr, east: east_addr,
                                  south: south_addr, west: west_addr};
        end
        if (cmd.fetch)
        begin
            nb_rd_reg <= nb_mem[fetch_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_push)
        begin
            stack_mem[0] <= '{id: tgcw_pkg::TILE_W'(scan_reg), x: '0, y: '0};
        end
        else if (push_ok)
        begin
            stack_mem[top_reg[IDX_W-1:0]] <= '{id: tgcw_pkg::TILE_W'(push_idx),
                                               x: push_x, y: push_y};
        end
        if (cmd.pop)
        begin
            stack_rd_reg <= stack_mem[top_dec[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            raw_mem[fetch_idx] <= '{x: stack_rd_reg.x, y: stack_rd_reg.y};
        end
        if (cmd.emit_init)
        begin
            raw_rd_reg <= raw_mem[0];
        end
        else if (cmd.emit && !status.emit_end)
        begin
            raw_rd_reg <= raw_mem[cnt_inc];
        end
    end

    // Walk control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg   <= '0;
            visited_reg <= '0;
            placed_reg  <= '0;
            top_reg     <= '0;
            scan_reg    <= IDX_W'(1);
            cnt_reg     <= '0;
            any_reg     <= 1'b0;
            min_x_reg   <= '0;
            min_y_reg   <= '0;
            max_x_reg   <= '0;
            max_y_reg   <= '0;
        end
        else
        begin
            if (cmd.load && load_ok)
            begin
                alive_reg[load_idx] <= alive;
            end
            if (cmd.walk_init)
            begin
                visited_reg <= '0;
                placed_reg  <= '0;
                top_reg     <= '0;
                scan_reg    <= IDX_W'(1);
                any_reg     <= 1'b0;
                min_x_reg   <= '0;
                min_y_reg   <= '0;
                max_x_reg   <= '0;
                max_y_reg   <= '0;
            end
            if (cmd.scan_adv)
            begin
                scan_reg <= scan_reg + IDX_W'(1);
            end
            if (cmd.start_push)
            begin
                visited_reg[scan_reg] <= 1'b1;
                top_reg               <= CNT_W'(1);
                any_reg               <= 1'b1;
            end
            if (cmd.pop)
            begin
                top_reg <= top_dec;
            end
            if (cmd.fetch)
            begin
                placed_reg[fetch_idx] <= 1'b1;
                if (stack_rd_reg.x < min_x_reg) min_x_reg <= stack_rd_reg.x;
                if (stack_rd_reg.y < min_y_reg) min_y_reg <= stack_rd_reg.y;
                if (stack_rd_reg.x > max_x_reg) max_x_reg <= stack_rd_reg.x;
                if (stack_rd_reg.y > max_y_reg) max_y_reg <= stack_rd_reg.y;
            end
            if (push_ok)
            begin
                visited_reg[push_idx] <= 1'b1;
                top_reg               <= top_reg + CNT_W'(1);
            end
            if (cmd.emit_init)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.emit)
            begin
                cnt_reg <= cnt_inc;
            end
        end
    end

    // Result word
    assign cur_placed = placed_reg[cnt_reg];
    assign shift_x    = raw_rd_reg.x - min_x_reg;
    assign shift_y    = raw_rd_reg.y - min_y_reg;
    assign span_x     = tgcw_pkg::SIZE_W'(max_x_reg - min_x_reg) + tgcw_pkg::SIZE_W'(1);
    assign span_y     = tgcw_pkg::SIZE_W'(max_y_reg - min_y_reg) + tgcw_pkg::SIZE_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_tile_reg   <= tgcw_pkg::TILE_W'(cnt_reg);
            placed_out_reg <= cur_placed;
            grid_x_reg     <= cur_placed ? shift_x[tgcw_pkg::TILE_W-1:0] : '0;
            grid_y_reg     <= cur_placed ? shift_y[tgcw_pkg::TILE_W-1:0] : '0;
            width_reg      <= any_reg ? span_x : '0;
            height_reg     <= any_reg ? span_y : '0;
            last_reg       <= status.emit_end;
        end
    end

    assign strobe     = strobe_reg;
    assign out_tile   = out_tile_reg;
    assign placed     = placed_out_reg;
    assign grid_x     = grid_x_reg;
    assign grid_y     = grid_y_reg;
    assign map_width  = width_reg;
    assign map_height = height_reg;
    assign last       = last_reg;

endmodule

// ===== dv/tb_tile_grid_coordinate_walk_unit.sv =====
// Testbench for the tile grid coordinate walk unit: table loads, walks and per-tile results.
module tb_tile_grid_coordinate_walk_unit;

    import tgcw_pkg::*;

    localparam int TILES = TILE_COUNT_DEF;

    // Word kinds carried on the action port.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_WALK = 1'b1;

    // Stop drawing new sequences once this many words have gone in.
    localparam int WORD_TARGET = 330;

    // Keep the log short if the block goes badly wrong.
    localparam int REPORT_CAP = 100;

    typedef enum int {
        SHAPE_BLOB,
        SHAPE_ROW,
        SHAPE_COLUMN
    } shape_kind_t;

    // One expected tile result of a walk.
    typedef struct {
        logic [TILE_W-1:0] tile;
        logic              placed;
        logic [TILE_W-1:0] gx;
        logic [TILE_W-1:0] gy;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic              last;
    } tile_result_t;

    // Tile table mirror, walk predictor and result checker.
    class placement_board;
        bit           tile_alive [TILES];
        nb_entry_t    tile_links [TILES];
        bit           seen       [TILES];
        bit           reached    [TILES];
        int           pos_x      [TILES];
        int           pos_y      [TILES];
        int           stack_id   [TILES];
        int           stack_x    [TILES];
        int           stack_y    [TILES];
        int           stack_depth;
        tile_result_t pending_placements [$];
        int           mismatch_count;
        int           loads;
        int           walks;
        int           populated_walks;
        int           results_checked;
        int           widest;
        int           tallest;

        task report_mismatch(string msg);
            if (mismatch_count < REPORT_CAP)
            begin
                $display("MISMATCH at %0t: %s", $time, msg);
            end
            mismatch_count++;
        endtask

        // Push a neighbour unless it is absent, dead, already seen or the stack is full.
        function void stack_tile(int addr, int x, int y);
            if (addr == 0 || addr >= TILES)
                return;
            if (seen[addr] || !tile_alive[addr])
                return;
            if (stack_depth >= TILES)
                return;
            stack_id[stack_depth] = addr;
            stack_x[stack_depth]  = x;
            stack_y[stack_depth]  = y;
            seen[addr]            = 1'b1;
            stack_depth++;
        endfunction

        function void predict_walk();
            tile_result_t r;
            int i;
            int first;
            int id;
            int x;
            int y;
            int lo_x;
            int lo_y;
            int wid;
            int hgt;
            first       = 0;
            lo_x        = 0;
            lo_y        = 0;
            wid         = 0;
            hgt         = 0;
            stack_depth = 0;
            for (i = 0; i < TILES; i++)
            begin
                seen[i]    = 1'b0;
                reached[i] = 1'b0;
                pos_x[i]   = 0;
                pos_y[i]   = 0;
            end
            // Tile zero is never a start tile.
            for (i = TILES - 1; i >= 1; i--)
            begin
                if (tile_alive[i])
                    first = i;
            end
            if (first != 0)
            begin
                stack_id[0] = first;
                stack_x[0]  = 0;
                stack_y[0]  = 0;
                seen[first] = 1'b1;
                stack_depth = 1;
                while (stack_depth > 0)
                begin
                    stack_depth--;
                    id = stack_id[stack_depth];
                    x  = stack_x[stack_depth];
                    y  = stack_y[stack_depth];
                    reached[id] = 1'b1;
                    pos_x[id]   = x;
                    pos_y[id]   = y;
                    if (x < lo_x)
                        lo_x = x;
                    if (y < lo_y)
                        lo_y = y;
                    stack_tile(tile_links[id].north, x, y - 1);
                    stack_tile(tile_links[id].east, x + 1, y);
                    stack_tile(tile_links[id].south, x, y + 1);
                    stack_tile(tile_links[id].west, x - 1, y);
                end
                for (i = 0; i < TILES; i++)
                begin
                    if (reached[i])
                    begin
                        if (pos_x[i] - lo_x + 1 > wid)
                            wid = pos_x[i] - lo_x + 1;
                        if (pos_y[i] - lo_y + 1 > hgt)
                            hgt = pos_y[i] - lo_y + 1;
                    end
                end
                populated_walks++;
            end
            for (i = 0; i < TILES; i++)
            begin
                r.tile   = TILE_W'(i);
                r.placed = reached[i];
                r.gx     = reached[i] ? TILE_W'(pos_x[i] - lo_x) : '0;
                r.gy     = reached[i] ? TILE_W'(pos_y[i] - lo_y) : '0;
                r.width  = SIZE_W'(wid);
                r.height = SIZE_W'(hgt);
                r.last   = (i == TILES - 1);
                pending_placements.push_back(r);
            end
            if (wid > widest)
                widest = wid;
            if (hgt > tallest)
                tallest = hgt;
            walks++;
        endfunction

        function void note_word(logic act, logic [TILE_W-1:0] idx, logic alv,
                                logic [ADDR_W-1:0] n, logic [ADDR_W-1:0] e,
                                logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] w);
            if (act == ACT_LOAD)
            begin
                tile_alive[idx]       = alv;
                tile_links[idx].north = n;
                tile_links[idx].east  = e;
                tile_links[idx].south = s;
                tile_links[idx].west  = w;
                loads++;
            end
            else
            begin
                predict_walk();
            end
        endfunction

        task compare_field(string name, logic [6:0] got, logic [6:0] want,
                           logic [TILE_W-1:0] tile);
            if (got !== want)
                report_mismatch($sformatf("tile %0d %s: got %0d, expected %0d",
                                          tile, name, got, want));
        endtask

        task check_result(logic [TILE_W-1:0] tile, logic plc, logic [TILE_W-1:0] gx,
                          logic [TILE_W-1:0] gy, logic [SIZE_W-1:0] mw,
                          logic [SIZE_W-1:0] mh, logic lst);
            tile_result_t want;
            if (pending_placements.size() == 0)
            begin
                report_mismatch($sformatf("result for tile %0d with no walk outstanding", tile));
                return;
            end
            want = pending_placements.pop_front();
            results_checked++;
            compare_field("out_tile", 7'(tile), 7'(want.tile), want.tile);
            compare_field("placed", 7'(plc), 7'(want.placed), want.tile);
            compare_field("grid_x", 7'(gx), 7'(want.gx), want.tile);
            compare_field("grid_y", 7'(gy), 7'(want.gy), want.tile);
            compare_field("map_width", mw, want.width, want.tile);
            compare_field("map_height", mh, want.height, want.tile);
            compare_field("last", 7'(lst), 7'(want.last), want.tile);
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              action;
    logic [TILE_W-1:0] tile_index;
    logic              alive;
    logic [ADDR_W-1:0] north_addr;
    logic [ADDR_W-1:0] east_addr;
    logic [ADDR_W-1:0] south_addr;
    logic [ADDR_W-1:0] west_addr;
    logic              strobe;
    logic [TILE_W-1:0] out_tile;
    logic              placed;
    logic [TILE_W-1:0] grid_x;
    logic [TILE_W-1:0] grid_y;
    logic [SIZE_W-1:0] map_width;
    logic [SIZE_W-1:0] map_height;
    logic              last;

    placement_board board;

    // Sender burst bookkeeping.
    int burst_left;
    int words_sent;

    // Tiles of the most recently built shape: address and intended grid cell.
    int shape_size;
    int shape_addr [TILES];
    int shape_x    [TILES];
    int shape_y    [TILES];

    tile_grid_coordinate_walk_unit dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .tile_index (tile_index),
        .alive      (alive),
        .north_addr (north_addr),
        .east_addr  (east_addr),
        .south_addr (south_addr),
        .west_addr  (west_addr),
        .strobe     (strobe),
        .out_tile   (out_tile),
        .placed     (placed),
        .grid_x     (grid_x),
        .grid_y     (grid_y),
        .map_width  (map_width),
        .map_height (map_height),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #10000000;
        $display("Timeout: walk results still outstanding");
        $display("Test completed with failures");
        $finish;
    end

    // Take every result word on the edge that ends its cycle; the block cannot be held off.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            board.check_result(out_tile, placed, grid_x, grid_y, map_width, map_height, last);
    end

    function automatic int dir_dx(dir_t d);
        return (d == DIR_E) ? 1 : (d == DIR_W) ? -1 : 0;
    endfunction

    function automatic int dir_dy(dir_t d);
        return (d == DIR_S) ? 1 : (d == DIR_N) ? -1 : 0;
    endfunction

    // Index of the first shape tile below limit that sits on cell (x, y), or -1.
    function automatic int cell_owner(int x, int y, int limit);
        int k;
        int owner;
        owner = -1;
        for (k = limit - 1; k >= 0; k--)
        begin
            if (shape_x[k] == x && shape_y[k] == y)
                owner = k;
        end
        return owner;
    endfunction

    // Mix of absent, in-range and out-of-range neighbour addresses.
    function automatic logic [ADDR_W-1:0] rand_link();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return ADDR_W'($urandom_range(1, TILES - 1));
            2:       return ADDR_W'($urandom_range(TILES, 255));
            default: return ADDR_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Hand one word to the block and hold it until accepted. Open a new burst with a
    // random gap whenever the current one runs out; scramble the idle fields meanwhile.
    task automatic send_word(logic act, logic [TILE_W-1:0] idx, logic alv,
                             logic [ADDR_W-1:0] n, logic [ADDR_W-1:0] e,
                             logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] w);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            start      = 1'b0;
            action     = 1'($urandom);
            tile_index = TILE_W'($urandom);
            alive      = 1'($urandom);
            north_addr = ADDR_W'($urandom);
            east_addr  = ADDR_W'($urandom);
            south_addr = ADDR_W'($urandom);
            west_addr  = ADDR_W'($urandom);
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        start      = 1'b1;
        action     = act;
        tile_index = idx;
        alive      = alv;
        north_addr = n;
        east_addr  = e;
        south_addr = s;
        west_addr  = w;
        do
            @(posedge clk);
        while (busy);
        board.note_word(act, idx, alv, n, e, s, w);
        burst_left--;
        words_sent++;
    endtask

    task automatic load_tile(int idx, logic alv, int n, int e, int s, int w);
        send_word(ACT_LOAD, TILE_W'(idx), alv, ADDR_W'(n), ADDR_W'(e), ADDR_W'(s), ADDR_W'(w));
    endtask

    // Walk words carry random payload; the block must ignore it.
    task automatic run_walk();
        send_word(ACT_WALK, TILE_W'($urandom), 1'($urandom), rand_link(), rand_link(),
                  rand_link(), rand_link());
    endtask

    // Drop start and hold off until every outstanding tile result has come out.
    task automatic wait_for_results();
        @(negedge clk);
        start      = 1'b0;
        burst_left = 0;
        while (board.pending_placements.size() != 0)
            @(posedge clk);
    endtask

    // Build a connected shape of count tiles on distinct random addresses and load it
    // with consistent neighbour links, a little noise in the unused and stray links.
    task automatic place_shape(int count, shape_kind_t kind);
        int   pool [TILES-1];
        int   j;
        int   k;
        int   tmp;
        int   parent;
        int   tries;
        int   nx;
        int   ny;
        int   owner;
        int   dn;
        int   link [4];
        dir_t d;
        dir_t line_dir;
        for (k = 0; k < TILES - 1; k++)
            pool[k] = k + 1;
        for (k = TILES - 2; k > 0; k--)
        begin
            j       = $urandom_range(0, k);
            tmp     = pool[k];
            pool[k] = pool[j];
            pool[j] = tmp;
        end
        if (kind == SHAPE_ROW)
            line_dir = $urandom_range(0, 1) ? DIR_E : DIR_W;
        else
            line_dir = $urandom_range(0, 1) ? DIR_N : DIR_S;
        shape_size = count;
        for (k = 0; k < count; k++)
            shape_addr[k] = pool[k];
        shape_x[0] = 0;
        shape_y[0] = 0;
        // Grow from existing tiles; give up on avoiding overlap after a few tries.
        for (k = 1; k < count; k++)
        begin
            tries = 0;
            do
            begin
                parent = (kind == SHAPE_BLOB) ? $urandom_range(0, k - 1) : k - 1;
                d      = (kind == SHAPE_BLOB) ? dir_t'($urandom_range(0, 3)) : line_dir;
                nx     = shape_x[parent] + dir_dx(d);
                ny     = shape_y[parent] + dir_dy(d);
                tries++;
            end
            while (cell_owner(nx, ny, k) >= 0 && tries < 8);
            shape_x[k] = nx;
            shape_y[k] = ny;
        end
        for (k = 0; k < count; k++)
        begin
            for (dn = 0; dn < 4; dn++)
            begin
                owner = cell_owner(shape_x[k] + dir_dx(dir_t'(dn)),
                                   shape_y[k] + dir_dy(dir_t'(dn)), count);
                if (owner >= 0)
                    link[dn] = shape_addr[owner];
                else
                    link[dn] = ($urandom_range(0, 3) == 0) ? $urandom_range(TILES, 255) : 0;
                if ($urandom_range(0, 19) == 0)
                    link[dn] = $urandom_range(0, 255);
            end
            load_tile(shape_addr[k], 1'b1, link[DIR_N], link[DIR_E], link[DIR_S], link[DIR_W]);
        end
    endtask

    // Kill the tiles of the last shape so the next walk starts on fresh ground.
    task automatic retire_shape();
        int k;
        for (k = 0; k < shape_size; k++)
            load_tile(shape_addr[k], 1'b0, rand_link(), rand_link(), rand_link(), rand_link());
        shape_size = 0;
    endtask

    initial
    begin
        int seq_no;
        int pick;
        board      = new();
        burst_left = 0;
        words_sent = 0;
        shape_size = 0;
        seq_no     = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        action     = ACT_LOAD;
        tile_index = '0;
        alive      = 1'b0;
        north_addr = '0;
        east_addr  = '0;
        south_addr = '0;
        west_addr  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk with nothing alive: every tile unplaced, both sizes zero.
        run_walk();
        // Tile zero alive on its own is never a start tile nor a neighbour.
        load_tile(0, 1'b1, 1, 2, 3, 63);
        run_walk();
        // Small hook-shaped map; tile 9 lands on the cell of tile 5 (overlap goes
        // unnoticed), tile 63 sits west of it, and stray links point at 0, 64, 128, 200, 255.
        load_tile(5, 1'b1, 0, 6, 255, 64);
        load_tile(6, 1'b1, 5, 0, 7, 5);
        load_tile(7, 1'b1, 6, 128, 0, 8);
        load_tile(8, 1'b1, 9, 7, 200, 0);
        load_tile(9, 1'b1, 8, 0, 0, 63);
        load_tile(63, 1'b1, 255, 255, 255, 255);
        run_walk();
        // Same table again: every walk starts from a clean slate.
        run_walk();
        // Kill the start tile so the walk moves on to the next alive tile.
        load_tile(5, 1'b0, 0, 0, 0, 0);
        run_walk();
        // A lone tile at the lowest address gives a one-by-one map.
        load_tile(1, 1'b1, 0, 0, 0, 0);
        run_walk();
        load_tile(1, 1'b0, 255, 255, 255, 255);
        load_tile(0, 1'b0, 0, 0, 0, 0);
        wait_for_results();

        // Mostly well-formed shapes followed by a walk; a full row and a full column
        // first to reach the widest and tallest maps, then smaller shapes and some noise.
        while (words_sent < WORD_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (seq_no == 0)
            begin
                retire_shape();
                place_shape(TILES - 1, SHAPE_ROW);
                run_walk();
            end
            else if (seq_no == 1)
            begin
                place_shape(TILES - 1, SHAPE_COLUMN);
                run_walk();
            end
            else if (pick < 2)
            begin
                repeat ($urandom_range(1, 6))
                    load_tile($urandom_range(0, TILES - 1), 1'($urandom), rand_link(),
                              rand_link(), rand_link(), rand_link());
                if ($urandom_range(0, 1))
                    run_walk();
            end
            else
            begin
                if (shape_size <= 12 || $urandom_range(0, 1))
                    retire_shape();
                if (pick == 2)
                    place_shape($urandom_range(16, TILES - 1), SHAPE_BLOB);
                else if (pick == 3)
                    place_shape($urandom_range(2, 10),
                                $urandom_range(0, 1) ? SHAPE_ROW : SHAPE_COLUMN);
                else
                    place_shape($urandom_range(1, 10), SHAPE_BLOB);
                run_walk();
            end
            // Let the pipe drain completely now and then before carrying on.
            if (seq_no % 7 == 6)
                wait_for_results();
            seq_no++;
        end

        wait_for_results();
        repeat (TILES + 16) @(posedge clk);

        if (board.pending_placements.size() != 0)
            board.report_mismatch($sformatf("%0d tile results never arrived",
                                            board.pending_placements.size()));

        $display("Covered %0d words: %0d table loads and %0d walks, %0d of them placing tiles",
                 words_sent, board.loads, board.walks, board.populated_walks);
        $display("Checked %0d tile results; widest map %0d columns, tallest %0d rows",
                 board.results_checked, board.widest, board.tallest);
        if (board.mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
